// ===== design/lcft_pkg.sv =====
`default_nettype none

package lcft_pkg;

  // Field and register widths
  localparam int unsigned ELAPSED_W = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned SEG_W     = 7;
  localparam int unsigned TRAIL_W   = 6;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned IDX_W     = 6;

  // APB port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RIDX_W = 3;

  // Register indexes (byte address / 4)
  localparam logic [RIDX_W-1:0] REG_PERIOD  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_SEGLEN  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_TRAIL   = 3'd2;
  localparam logic [RIDX_W-1:0] REG_REVERSE = 3'd3;
  localparam logic [RIDX_W-1:0] REG_COLOR   = 3'd4;

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
  localparam logic [SEG_W-1:0]    SEGLEN_RST = 7'd10;
  localparam logic [TRAIL_W-1:0]  TRAIL_RST  = 6'd3;
  localparam logic                REVERSE_RST = 1'b0;
  localparam logic [COLOR_W-1:0]  COLOR_RST  = 24'hFF0000;

  localparam int unsigned MAX_LEDS_DEF = 64;

  // Shared divider
  localparam int unsigned DIV_W     = 32;
  localparam int unsigned DIVISOR_W = 16;
  localparam int unsigned STEPS_W   = 6;
  localparam int unsigned FADE_W    = CHAN_W + TRAIL_W;
  localparam int unsigned DIM_SHIFT = 3;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [SEG_W-1:0]    seg_len;
    logic [TRAIL_W-1:0]  trail;
    logic                rev;
    logic [COLOR_W-1:0]  color;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
    logic [STEPS_W-1:0]   steps;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_W-1:0]     quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== design/lcft_regs.sv =====
`default_nettype none

module lcft_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcft_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcft_pkg::DATA_W-1:0]  pwdata,
  output logic [lcft_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output lcft_pkg::cfg_t               cfg_o
);
  import lcft_pkg::*;

  cfg_t              cfg_q;
  logic [RIDX_W-1:0] ridx;
  logic              wr_en;

  assign ridx   = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period  <= PERIOD_RST;
      cfg_q.seg_len <= SEGLEN_RST;
      cfg_q.trail   <= TRAIL_RST;
      cfg_q.rev     <= REVERSE_RST;
      cfg_q.color   <= COLOR_RST;
    end else if (wr_en) begin
      unique case (ridx)
        REG_PERIOD:  cfg_q.period  <= pwdata[PERIOD_W-1:0];
        REG_SEGLEN:  cfg_q.seg_len <= pwdata[SEG_W-1:0];
        REG_TRAIL:   cfg_q.trail   <= pwdata[TRAIL_W-1:0];
        REG_REVERSE: cfg_q.rev     <= pwdata[0];
        REG_COLOR:   cfg_q.color   <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PERIOD:  prdata = DATA_W'(cfg_q.period);
      REG_SEGLEN:  prdata = DATA_W'(cfg_q.seg_len);
      REG_TRAIL:   prdata = DATA_W'(cfg_q.trail);
      REG_REVERSE: prdata = DATA_W'(cfg_q.rev);
      REG_COLOR:   prdata = DATA_W'(cfg_q.color);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/lcft_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller left-aligns the
// dividend so that its significant bits are the top `steps` bits.
module lcft_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcft_pkg::div_req_t req_i,
  output lcft_pkg::div_rsp_t rsp_o
);
  import lcft_pkg::*;

  logic [DIV_W-1:0]     quo_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] dvs_q;
  logic [STEPS_W-1:0]   cnt_q;
  logic                 busy_q;
  logic                 done_q;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - STEPS_W'(1);
        if (cnt_q == STEPS_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

// ===== design/led_chase_with_fading_trail_unit.sv =====
`default_nettype none

// Channel   | Direction | Handshake                   | Payload
// ----------+-----------+-----------------------------+-------------------------------------
// frame in  | input     | in_valid_i / in_stall_o     | elapsed_ms_i
// LED out   | output    | out_valid_o / out_stall_i   | led_index_o, red_o, green_o, blue_o,
//           |           |                             | last_o
// config    | APB       | psel/penable/pwrite, pready | paddr, pwdata, prdata
//
// One frame runs start to finish through a single serial divider (one bit per
// cycle): elapsed / period, that quotient mod length and trail mod length.
// Each LED then passes an evaluate state and a beat state, and a trail LED
// adds three 14-bit divisions to scale red, green and blue.
// in_stall_o is high from the accepted frame until its last beat is taken.
// out_stall_i holds the current beat in its registers; nothing else moves.
// Reset returns the sequencer to idle and loads the register defaults.
module led_chase_with_fading_trail_unit #(
  parameter int unsigned MAX_LEDS = lcft_pkg::MAX_LEDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // frame requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lcft_pkg::ELAPSED_W-1:0] elapsed_ms_i,
  // LED beats
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lcft_pkg::IDX_W-1:0]     led_index_o,
  output logic [lcft_pkg::CHAN_W-1:0]    red_o,
  output logic [lcft_pkg::CHAN_W-1:0]    green_o,
  output logic [lcft_pkg::CHAN_W-1:0]    blue_o,
  output logic                           last_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lcft_pkg::ADDR_W-1:0]    paddr,
  input  logic [lcft_pkg::DATA_W-1:0]    pwdata,
  output logic [lcft_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import lcft_pkg::*;

  // LED counter width: must hold the segment length itself
  localparam int unsigned NW = $clog2(MAX_LEDS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_BASE,
    ST_TMOD,
    ST_EVAL,
    ST_FADE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_e;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e   state_q;
  chan_e    chan_q;
  chan_e    chan_sel;
  logic [NW-1:0]     n_q, head_q, d_q, r_q, k_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              last_q;

  logic              in_acc, out_acc;
  logic [NW-1:0]     n_new, base, head_new;
  logic [CHAN_W-1:0] cr, cg, cb, c_sel;
  logic [NW:0]       diff;
  logic [TRAIL_W-1:0] num;
  logic [FADE_W-1:0] prod;
  logic              on_trail;
  logic [DIVISOR_W-1:0] period_eff;

  lcft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lcft_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == ST_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign cr = cfg.color[3*CHAN_W-1:2*CHAN_W];
  assign cg = cfg.color[2*CHAN_W-1:CHAN_W];
  assign cb = cfg.color[CHAN_W-1:0];

  // A zero period counts as one
  assign period_eff = (cfg.period == '0) ? DIVISOR_W'(1) : cfg.period;

  // Clamp the segment length into 1..MAX_LEDS
  always_comb begin
    if (cfg.seg_len == '0) begin
      n_new = NW'(1);
    end else if (int'(cfg.seg_len) > int'(MAX_LEDS)) begin
      n_new = NW'(MAX_LEDS);
    end else begin
      n_new = NW'(cfg.seg_len);
    end
  end

  assign base     = div_rsp.remainder[NW-1:0];
  assign head_new = cfg.rev ? (n_q - NW'(1) - base) : base;

  // d is the distance from the head against the run direction. The last trail
  // step to land here is the largest i <= trail with i == d (mod n), i >= 1,
  // whose fade numerator trail+1-i reduces to ((trail mod n) - d) mod n + 1.
  assign on_trail = (d_q != '0) ? (int'(cfg.trail) >= int'(d_q))
                                : (int'(cfg.trail) >= int'(n_q));
  assign diff = (r_q >= d_q) ? ({1'b0, r_q} - {1'b0, d_q})
                             : ({1'b0, r_q} + {1'b0, n_q} - {1'b0, d_q});
  assign num  = TRAIL_W'(diff + (NW + 1)'(1));

  always_comb begin
    if (state_q == ST_EVAL) begin
      chan_sel = CH_RED;
    end else begin
      unique case (chan_q)
        CH_RED:  chan_sel = CH_GREEN;
        default: chan_sel = CH_BLUE;
      endcase
    end
  end

  always_comb begin
    unique case (chan_sel)
      CH_RED:   c_sel = cr;
      CH_GREEN: c_sel = cg;
      default:  c_sel = cb;
    endcase
  end

  assign prod = FADE_W'(c_sel) * FADE_W'(num);

  // Divider requests
  always_comb begin
    div_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          div_req.start    = 1'b1;
          div_req.dividend = elapsed_ms_i;
          div_req.divisor  = period_eff;
          div_req.steps    = STEPS_W'(DIV_W);
        end
      end
      ST_QUOT: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = DIVISOR_W'(n_q);
          div_req.steps    = STEPS_W'(DIV_W);
        end
      end
      ST_BASE: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = {cfg.trail, (DIV_W - TRAIL_W)'(0)};
          div_req.divisor  = DIVISOR_W'(n_q);
          div_req.steps    = STEPS_W'(TRAIL_W);
        end
      end
      ST_EVAL: begin
        if (on_trail) begin
          div_req.start    = 1'b1;
          div_req.dividend = {prod, (DIV_W - FADE_W)'(0)};
          div_req.divisor  = DIVISOR_W'(cfg.trail) + DIVISOR_W'(1);
          div_req.steps    = STEPS_W'(FADE_W);
        end
      end
      ST_FADE: begin
        if (div_rsp.done && chan_q != CH_BLUE) begin
          div_req.start    = 1'b1;
          div_req.dividend = {prod, (DIV_W - FADE_W)'(0)};
          div_req.divisor  = DIVISOR_W'(cfg.trail) + DIVISOR_W'(1);
          div_req.steps    = STEPS_W'(FADE_W);
        end
      end
      default: ;
    endcase
  end

  // Sequencer and beat registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= CH_RED;
      n_q     <= '0;
      head_q  <= '0;
      d_q     <= '0;
      r_q     <= '0;
      k_q     <= '0;
      idx_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q     <= n_new;
            state_q <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          if (div_rsp.done) begin
            state_q <= ST_BASE;
          end
        end
        ST_BASE: begin
          if (div_rsp.done) begin
            head_q  <= head_new;
            state_q <= ST_TMOD;
          end
        end
        ST_TMOD: begin
          if (div_rsp.done) begin
            r_q <= div_rsp.remainder[NW-1:0];
            k_q <= '0;
            // distance of LED 0 from the head
            if (cfg.rev) begin
              d_q <= (head_q == '0) ? '0 : (n_q - head_q);
            end else begin
              d_q <= head_q;
            end
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          idx_q  <= IDX_W'(k_q);
          last_q <= (k_q == n_q - NW'(1));
          if (on_trail) begin
            chan_q  <= CH_RED;
            state_q <= ST_FADE;
          end else begin
            if (d_q == '0) begin
              red_q   <= cr;
              green_q <= cg;
              blue_q  <= cb;
            end else begin
              red_q   <= cr >> DIM_SHIFT;
              green_q <= cg >> DIM_SHIFT;
              blue_q  <= cb >> DIM_SHIFT;
            end
            state_q <= ST_OUT;
          end
        end
        ST_FADE: begin
          if (div_rsp.done) begin
            unique case (chan_q)
              CH_RED: begin
                red_q  <= div_rsp.quotient[CHAN_W-1:0];
                chan_q <= CH_GREEN;
              end
              CH_GREEN: begin
                green_q <= div_rsp.quotient[CHAN_W-1:0];
                chan_q  <= CH_BLUE;
              end
              default: begin
                blue_q  <= div_rsp.quotient[CHAN_W-1:0];
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            if (last_q) begin
              state_q <= ST_IDLE;
            end else begin
              // advance one LED: distance steps against the run direction
              k_q <= k_q + NW'(1);
              if (cfg.rev) begin
                d_q <= (d_q == n_q - NW'(1)) ? '0 : (d_q + NW'(1));
              end else begin
                d_q <= (d_q == '0) ? (n_q - NW'(1)) : (d_q - NW'(1));
              end
              state_q <= ST_EVAL;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign led_index_o = idx_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign last_o      = last_q;

  // A divider result only shows up while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_QUOT || state_q == ST_BASE ||
                      state_q == ST_TMOD || state_q == ST_FADE))
    else $error("divider finished outside a wait state");

  // The divider is never restarted mid-division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The last beat carries the top LED index of the segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (led_index_o == IDX_W'(n_q - NW'(1))))
    else $error("last beat on wrong LED");

  // Taking the last beat frees the input side in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> !in_stall_o)
    else $error("frame input not released after last beat");

endmodule

`default_nettype wire
